### src/http_frame_start_finder_macros.svh
// ----------------------------------------------------------------------------
// HTTP frame start finder assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_FRAME_START_FINDER_MACROS_SVH
`define HTTP_FRAME_START_FINDER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HFSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define HFSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/hfsf_pkg.sv
// ----------------------------------------------------------------------------
// HTTP frame start finder package
// Widths, register indexes, the message-start pattern table and shared types.
// ----------------------------------------------------------------------------
package hfsf_pkg;

    // Position counters wrap at this width.
    localparam int POS_BITS      = 32;
    localparam int HIST_LEN      = 9;
    localparam int NUM_PAT       = 12;
    localparam int MARKER_IDX    = 11;
    localparam int LEN_BITS      = 4;
    localparam int MODE_BITS     = 2;
    localparam int OFFSET_BITS   = 32;
    localparam int RESULT_BITS   = 32;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    typedef logic [7:0]              byte_t;
    typedef logic [POS_BITS-1:0]     pos_t;
    typedef logic [NUM_PAT-1:0]      pat_vec_t;
    typedef logic [HIST_LEN*8-1:0]   pat_text_t;
    typedef logic [LEN_BITS-1:0]     pat_len_t;
    typedef logic [MODE_BITS-1:0]    mode_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    // Message type codes.
    localparam mode_t MODE_UNKNOWN  = 2'd0;
    localparam mode_t MODE_REQUEST  = 2'd1;
    localparam mode_t MODE_RESPONSE = 2'd2;

    // Configuration register indexes.
    localparam cfg_idx_t REG_MESSAGE_TYPE = 1'b0;
    localparam cfg_idx_t REG_START_OFFSET = 1'b1;

    // Pattern groups enabled by each message type.
    localparam pat_vec_t REQUEST_SET  = 12'b0000_0001_1111_1111;
    localparam pat_vec_t RESPONSE_SET = 12'b0110_0000_0000;

    // Pattern text, right aligned: the final character sits in the low byte.
    // The last entry is the CR LF CR LF end-of-header marker.
    localparam pat_text_t PAT_TEXT [NUM_PAT] = '{
        pat_text_t'("GET "),
        pat_text_t'("HEAD "),
        pat_text_t'("POST "),
        pat_text_t'("PUT "),
        pat_text_t'("DELETE "),
        pat_text_t'("CONNECT "),
        pat_text_t'("OPTIONS "),
        pat_text_t'("TRACE "),
        pat_text_t'("PATCH "),
        pat_text_t'("HTTP/1.1 "),
        pat_text_t'("HTTP/1.0 "),
        pat_text_t'({8'h0D, 8'h0A, 8'h0D, 8'h0A})
    };

    localparam pat_len_t PAT_LEN [NUM_PAT] = '{
        4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd8, 4'd6, 4'd6, 4'd9, 4'd9, 4'd4
    };

    // Control handed from the sequencer to every history cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Expected character of pattern p at distance j back from the newest byte.
    function automatic byte_t pat_char(input int p, input int j);
        return PAT_TEXT[p][8*j +: 8];
    endfunction

    // Whether distance j lies inside pattern p.
    function automatic logic pat_care(input int p, input int j);
        return j < int'(PAT_LEN[p]);
    endfunction

endpackage

### src/http_frame_start_finder.sv
// ----------------------------------------------------------------------------
// HTTP frame start finder
// Finds the latest message-start pattern before the first end-of-header
// marker preceded by one in a byte stream, and reports its absolute position.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the in channel (data_byte, last_byte) with in_valid and
//   in_ready; one result per buffer leaves on the out channel (found,
//   start_position) with out_valid and out_ready. message_type (index 0) and
//   start_offset (index 1) are written on the cfg channel, which is always
//   ready. Write them only while no buffer is in flight; the block does not
//   check this. One byte is taken every cycle while in_ready is high. The
//   byte runs through a row of nine history cells, each comparing its byte
//   against every pattern, so a marker or a pattern is seen in the cycle its
//   last byte arrives. A result is visible on the out channel in the cycle
//   after the byte that caused it was accepted. The single output register
//   decides the rate under back pressure: while a result waits and out_ready
//   is low, in_ready is low; a result taken that cycle frees the slot.
//   Reset clears the history, the position counters and the output valid
//   flag, sets message_type to unknown and start_offset to zero. After the last
//   byte of a buffer the search state returns to that reset state, with the
//   registers kept.
// ----------------------------------------------------------------------------
`include "http_frame_start_finder_macros.svh"

module http_frame_start_finder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  hfsf_pkg::byte_t                     data_byte,
    input  logic                                last_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [hfsf_pkg::RESULT_BITS-1:0]    start_position,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  hfsf_pkg::cfg_idx_t                  cfg_index,
    input  logic [hfsf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import hfsf_pkg::*;

    // Configuration registers.
    mode_t                  message_type_reg;
    logic [OFFSET_BITS-1:0] start_offset_reg;

    // Search state.
    pos_t i_reg,          i_next;
    pos_t seg_reg,        seg_next;
    pos_t d_reg,          d_next;
    pos_t best_start_reg, best_start_next;
    pos_t best_off_reg,   best_off_next;
    logic best_valid_reg, best_valid_next;
    logic done_reg,       done_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg,     found_next;
    logic [RESULT_BITS-1:0] start_position_reg, start_position_next;

    logic       in_accept;
    logic       cfg_accept;
    cell_ctrl_t cell_ctrl;
    byte_t      hist [HIST_LEN+1];
    pat_vec_t   cell_match [HIST_LEN];
    pat_vec_t   tail_match;
    pat_vec_t   mode_set;
    logic       hit;
    pat_len_t   hit_len_m1;
    logic       marker_hit;
    pos_t       hit_off;
    pos_t       hit_start;
    pos_t       abs_pos;
    logic       emit;
    logic       emit_found;

    assign in_ready   = !out_valid_reg || out_ready;
    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            message_type_reg <= MODE_UNKNOWN;
            start_offset_reg <= '0;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                REG_MESSAGE_TYPE: message_type_reg <= cfg_data[MODE_BITS-1:0];
                REG_START_OFFSET: start_offset_reg <= cfg_data[OFFSET_BITS-1:0];
                default:          message_type_reg <= message_type_reg;
            endcase
        end
    end

    // History line: each byte taken while not done enters cell 0 and moves one cell.
    assign cell_ctrl.shift = in_accept && !done_reg;
    assign cell_ctrl.clear = in_accept && last_byte;
    assign hist[0]         = data_byte;

    for (genvar j = 0; j < HIST_LEN; j++)
    begin : g_cell
        byte_t    cell_ref [NUM_PAT];
        pat_vec_t cell_care;

        always_comb
        begin
            for (int p = 0; p < NUM_PAT; p++)
            begin
                cell_ref[p]  = pat_char(p, j);
                cell_care[p] = pat_care(p, j);
            end
        end

        hfsf_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .shift_in  (hist[j]),
            .ref_chars (cell_ref),
            .care      (cell_care),
            .shift_out (hist[j+1]),
            .match     (cell_match[j])
        );
    end

    // A pattern matches when every cell agrees.
    always_comb
    begin
        tail_match = '1;
        for (int j = 0; j < HIST_LEN; j++)
        begin
            tail_match = tail_match & cell_match[j];
        end
    end

    // Patterns enabled by the message type.
    always_comb
    begin
        case (message_type_reg)
            MODE_REQUEST:  mode_set = REQUEST_SET;
            MODE_RESPONSE: mode_set = RESPONSE_SET;
            default:       mode_set = '0;
        endcase
    end

    // Pattern and marker hits that lie wholly inside the current segment.
    // Patterns end in a space and none is a suffix of another, so at most one hits.
    always_comb
    begin
        hit        = 1'b0;
        hit_len_m1 = '0;
        for (int p = 0; p < MARKER_IDX; p++)
        begin
            if (mode_set[p] && tail_match[p] && d_reg >= pos_t'(PAT_LEN[p] - 4'd1))
            begin
                hit        = 1'b1;
                hit_len_m1 = PAT_LEN[p] - 4'd1;
            end
        end
        marker_hit = (mode_set != '0) && tail_match[MARKER_IDX] &&
                     d_reg >= pos_t'(PAT_LEN[MARKER_IDX] - 4'd1);
        hit_off    = d_reg - pos_t'(hit_len_m1);
        hit_start  = i_reg - pos_t'(hit_len_m1);
    end

    // Search sequencing for one accepted byte.
    always_comb
    begin
        i_next          = i_reg;
        seg_next        = seg_reg;
        d_next          = d_reg;
        best_start_next = best_start_reg;
        best_off_next   = best_off_reg;
        best_valid_next = best_valid_reg;
        done_next       = done_reg;
        emit            = 1'b0;
        emit_found      = 1'b0;

        if (in_accept)
        begin
            if (!done_reg)
            begin
                i_next = i_reg + pos_t'(1);
                d_next = d_reg + pos_t'(1);

                // The candidate farthest from the segment start wins.
                if (hit && (!best_valid_reg || hit_off > best_off_reg))
                begin
                    best_start_next = hit_start;
                    best_off_next   = hit_off;
                    best_valid_next = 1'b1;
                end

                // At the marker either report or restart the segment after it.
                if (marker_hit)
                begin
                    if (best_valid_next)
                    begin
                        emit       = 1'b1;
                        emit_found = 1'b1;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        seg_next        = i_reg + pos_t'(1);
                        d_next          = '0;
                        best_start_next = '0;
                        best_off_next   = '0;
                        best_valid_next = 1'b0;
                    end
                end
            end

            // End of buffer: report a miss if nothing was reported, then clear.
            if (last_byte)
            begin
                if (!emit && !done_reg)
                begin
                    emit = 1'b1;
                end
                i_next          = '0;
                seg_next        = '0;
                d_next          = '0;
                best_start_next = '0;
                best_off_next   = '0;
                best_valid_next = 1'b0;
                done_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg          <= '0;
            seg_reg        <= '0;
            d_reg          <= '0;
            best_start_reg <= '0;
            best_off_reg   <= '0;
            best_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            i_reg          <= i_next;
            seg_reg        <= seg_next;
            d_reg          <= d_next;
            best_start_reg <= best_start_next;
            best_off_reg   <= best_off_next;
            best_valid_reg <= best_valid_next;
            done_reg       <= done_next;
        end
    end

    // Output register load; a result only arrives when the slot is free.
    // A marker byte never completes a pattern, so the stored candidate is the
    // one reported, even when the marker is also the last byte.
    always_comb
    begin
        abs_pos             = pos_t'(start_offset_reg) + best_start_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        found_next          = found_reg;
        start_position_next = start_position_reg;
        if (emit)
        begin
            out_valid_next      = 1'b1;
            found_next          = emit_found;
            start_position_next = emit_found ? RESULT_BITS'(abs_pos) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg          <= found_next;
        start_position_reg <= start_position_next;
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign start_position = start_position_reg;

    // Checks on the search state and the output register.
    `HFSF_ASSERT(a_done_has_best, done_reg |-> best_valid_reg, "search done without a candidate")
    `HFSF_ASSERT(a_distance, (i_reg - seg_reg) == d_reg, "segment distance out of step")
    `HFSF_ASSERT(a_stall_blocks, !in_ready |-> out_valid_reg, "input stalled with empty output")
    `HFSF_ASSERT(a_miss_zero, (out_valid_reg && !found_reg) |-> (start_position_reg == '0), "miss with nonzero position")
    `HFSF_ASSERT_NEXT(a_last_reports, in_accept && last_byte && !done_reg, out_valid_reg, "last byte gave no result")

endmodule

### src/hfsf_cell.sv
// ----------------------------------------------------------------------------
// HTTP frame start finder history cell
// Holds one byte of the history line and compares the byte it is about to
// take against the character every pattern expects at this place.
// ----------------------------------------------------------------------------
module hfsf_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hfsf_pkg::cell_ctrl_t ctrl,
    input  hfsf_pkg::byte_t      shift_in,
    input  hfsf_pkg::byte_t      ref_chars [hfsf_pkg::NUM_PAT],
    input  hfsf_pkg::pat_vec_t   care,
    output hfsf_pkg::byte_t      shift_out,
    output hfsf_pkg::pat_vec_t   match
);
    import hfsf_pkg::*;

    byte_t hist_reg;
    byte_t hist_next;

    // Clear at the end of a buffer, otherwise take the neighbor's byte.
    always_comb
    begin
        hist_next = hist_reg;
        if (ctrl.clear)
        begin
            hist_next = '0;
        end
        else if (ctrl.shift)
        begin
            hist_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    // Places outside a pattern always agree.
    always_comb
    begin
        for (int p = 0; p < NUM_PAT; p++)
        begin
            match[p] = !care[p] || (shift_in == ref_chars[p]);
        end
    end

    assign shift_out = hist_reg;

endmodule

### tb/sv/http_frame_start_finder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP frame start finder testbench
// Streams short buffers of bytes, mostly well-formed request and response
// headers with random content, plus noise and truncated buffers, through the
// block under random idling and back pressure. A cycle-level predictor tracks
// the search state and the registers, and every result is checked in order.
// ----------------------------------------------------------------------------
module http_frame_start_finder_tb;
    import hfsf_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PERCENT  = 36;
    localparam int HISTORY_DEPTH = 9;
    localparam int WORD_COUNT    = 11;
    localparam int REQ_FIRST     = 0;
    localparam int REQ_COUNT     = 9;
    localparam int RSP_FIRST     = 9;
    localparam int RSP_COUNT     = 2;

    // Message type code that the block treats like unknown.
    localparam mode_t MODE_RESERVED = 2'd3;

    typedef struct {
        byte_t data;
        logic  last;
    } stream_byte_t;

    typedef struct {
        logic                   found;
        logic [RESULT_BITS-1:0] position;
    } frame_start_t;

    // Message-start words: nine request methods, then the two response lines.
    string start_words [WORD_COUNT] = '{
        "GET ", "HEAD ", "POST ", "PUT ", "DELETE ", "CONNECT ", "OPTIONS ",
        "TRACE ", "PATCH ", "HTTP/1.1 ", "HTTP/1.0 "
    };
    string end_of_header = "\015\012\015\012";
    string filler_chars  = "GETHADPOSUNCIRLM /.01\015\012";

    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     in_valid       = 1'b0;
    logic                     in_ready;
    byte_t                    data_byte      = '0;
    logic                     last_byte      = 1'b0;
    logic                     out_valid;
    logic                     out_ready      = 1'b0;
    logic                     found;
    logic [RESULT_BITS-1:0]   start_position;
    logic                     cfg_valid      = 1'b0;
    logic                     cfg_ready;
    cfg_idx_t                 cfg_index      = REG_MESSAGE_TYPE;
    logic [CFG_DATA_BITS-1:0] cfg_data       = '0;

    stream_byte_t byte_queue [$];
    frame_start_t expected_starts [$];
    byte_t        frame_bytes [$];

    // Predicted search state and registers.
    byte_t                  hist [HISTORY_DEPTH];
    pos_t                   scan_pos;
    pos_t                   seg_base;
    pos_t                   best_pos;
    logic                   best_ok;
    logic                   scan_done;
    mode_t                  cur_mode;
    logic [OFFSET_BITS-1:0] cur_offset;

    logic in_took     = 1'b0;
    logic calm        = 1'b0;
    logic hold_go     = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    int   cycle_count = 0;
    int   errors      = 0;

    http_frame_start_finder u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .start_position (start_position),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Return the search to its state at the start of a buffer.
    function automatic void clear_search();
        for (int k = 0; k < HISTORY_DEPTH; k++)
            hist[k] = '0;
        scan_pos  = '0;
        seg_base  = '0;
        best_pos  = '0;
        best_ok   = 1'b0;
        scan_done = 1'b0;
    endfunction

    // True when the newest bytes of the history spell the given text.
    function automatic bit history_ends_with(string text);
        int n;
        n = text.len();
        for (int j = 0; j < n; j++)
            if (hist[HISTORY_DEPTH - n + j] != byte_t'(text[j]))
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the search by one byte and queue the frame start it reports.
    function automatic void predict_byte(byte_t b, logic last);
        logic was_done;
        logic emitted;
        pos_t seg_dist;
        pos_t span;
        int   first;
        int   count;
        int   len;

        was_done = scan_done;
        emitted  = 1'b0;
        if (!scan_done)
        begin
            seg_dist = scan_pos - seg_base;
            for (int k = 0; k < HISTORY_DEPTH - 1; k++)
                hist[k] = hist[k + 1];
            hist[HISTORY_DEPTH - 1] = b;

            case (cur_mode)
                MODE_REQUEST:
                begin
                    first = REQ_FIRST;
                    count = REQ_COUNT;
                end
                MODE_RESPONSE:
                begin
                    first = RSP_FIRST;
                    count = RSP_COUNT;
                end
                default:
                begin
                    first = 0;
                    count = 0;
                end
            endcase

            // The candidate that starts farthest into the segment wins.
            for (int k = first; k < first + count; k++)
            begin
                len  = start_words[k].len();
                span = pos_t'(len - 1);
                if (seg_dist >= span && history_ends_with(start_words[k]))
                begin
                    if (!best_ok || (seg_dist - span) > (best_pos - seg_base))
                    begin
                        best_pos = scan_pos - span;
                        best_ok  = 1'b1;
                    end
                end
            end

            // End of header: report, or restart the segment after the marker.
            if (count != 0 && seg_dist >= pos_t'(3) && history_ends_with(end_of_header))
            begin
                if (best_ok)
                begin
                    expected_starts.push_back('{1'b1, cur_offset + best_pos});
                    emitted   = 1'b1;
                    scan_done = 1'b1;
                end
                else
                begin
                    seg_base = scan_pos + pos_t'(1);
                    best_ok  = 1'b0;
                    best_pos = '0;
                end
            end
            scan_pos = scan_pos + pos_t'(1);
        end

        if (last)
        begin
            if (!emitted && !was_done)
                expected_starts.push_back('{1'b0, '0});
            clear_search();
        end
    endfunction

    // Sampling at the rising edge: register writes, input requests, results.
    always @(posedge clk)
    begin
        frame_start_t want;
        if (!rst_n)
        begin
            in_took <= 1'b0;
            cur_mode   = MODE_UNKNOWN;
            cur_offset = '0;
            clear_search();
        end
        else
        begin
            in_took <= in_valid && in_ready;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MESSAGE_TYPE)
                    cur_mode = mode_t'(cfg_data[MODE_BITS-1:0]);
                else
                    cur_offset = cfg_data[OFFSET_BITS-1:0];
            end
            if (in_valid && in_ready)
                predict_byte(data_byte, last_byte);
            if (out_valid && out_ready)
            begin
                if (expected_starts.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result found=%0b start_position=%h",
                             $time, found, start_position);
                end
                else
                begin
                    want = expected_starts.pop_front();
                    if (found !== want.found)
                    begin
                        errors++;
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, found);
                    end
                    if (start_position !== want.position)
                    begin
                        errors++;
                        $display("%0t: start_position expected %h actual %h",
                                 $time, want.position, start_position);
                    end
                end
            end
        end
    end

    // Byte driver: holds each request until taken, with random gaps.
    always @(negedge clk)
    begin
        stream_byte_t item;
        if (rst_n && !(in_valid && !in_took))
        begin
            if (byte_queue.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PERCENT))
            begin
                item = byte_queue.pop_front();
                in_valid  <= 1'b1;
                data_byte <= item.data;
                last_byte <= item.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, and one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= rst_n && (calm || $urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every byte is taken and every result has come back.
    task automatic drain();
        while (byte_queue.size() != 0 || in_valid || expected_starts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_text(string text);
        for (int j = 0; j < text.len(); j++)
            frame_bytes.push_back(byte_t'(text[j]));
    endtask

    // Random filler, biased toward the characters of the start words.
    task automatic add_noise(int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(2) == 0)
                frame_bytes.push_back(byte_t'($urandom_range(255)));
            else
                frame_bytes.push_back(
                    byte_t'(filler_chars[$urandom_range(filler_chars.len() - 1)]));
        end
    endtask

    function automatic string mode_word(mode_t m);
        case (m)
            MODE_REQUEST:  return start_words[REQ_FIRST + $urandom_range(REQ_COUNT - 1)];
            MODE_RESPONSE: return start_words[RSP_FIRST + $urandom_range(RSP_COUNT - 1)];
            default:       return start_words[$urandom_range(WORD_COUNT - 1)];
        endcase
    endfunction

    // Hand the staged buffer to the driver, last flag on its final byte.
    task automatic send_frame();
        for (int k = 0; k < frame_bytes.size(); k++)
            byte_queue.push_back('{frame_bytes[k], k == frame_bytes.size() - 1});
        frame_bytes.delete();
    endtask

    // One random buffer: mostly a header block, else noise or a cut message.
    task automatic build_frame(mode_t m);
        int kind;
        int cut;
        kind = $urandom_range(99);
        if (kind < 65)
        begin
            if ($urandom_range(4) == 0)
            begin
                // A segment with no start word, so the search restarts.
                add_noise($urandom_range(0, 4));
                add_text(end_of_header);
                if ($urandom_range(1) == 0)
                    add_text("\015\012");
            end
            add_noise($urandom_range(0, 3));
            if ($urandom_range(2) == 0)
                add_text(mode_word(MODE_UNKNOWN));
            add_text(mode_word(m));
            add_noise($urandom_range(0, 6));
            add_text(end_of_header);
            add_noise($urandom_range(0, 4));
        end
        else if (kind < 80)
        begin
            add_noise($urandom_range(1, 12));
        end
        else
        begin
            add_text(mode_word(m));
            add_noise($urandom_range(0, 4));
            add_text(end_of_header);
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
        send_frame();
    endtask

    task automatic run_phase(mode_t m, logic [OFFSET_BITS-1:0] offset, int n_bytes,
                             bit quiet, bit with_hold);
        int sent;
        int queued;
        write_reg(REG_MESSAGE_TYPE, CFG_DATA_BITS'(m));
        write_reg(REG_START_OFFSET, offset);
        calm = quiet;
        sent = 0;
        // Frames are built in zero time, so the queue growth is the frame size.
        while (sent < n_bytes)
        begin
            queued = byte_queue.size();
            build_frame(m);
            sent += byte_queue.size() - queued;
        end
        if (with_hold)
        begin
            @(posedge clk);
            hold_go = !hold_go;
        end
        drain();
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Unknown mode after reset: a lone last byte gives not-found.
        frame_bytes.push_back(8'hFF);
        send_frame();
        drain();

        // Request mode: find on the last byte, a restart at buffer start,
        // a byte ignored after a find, and a lone zero byte.
        write_reg(REG_MESSAGE_TYPE, CFG_DATA_BITS'(MODE_REQUEST));
        write_reg(REG_START_OFFSET, '0);
        add_text("GET ");
        add_text(end_of_header);
        send_frame();
        add_text(end_of_header);
        add_text("HEAD ");
        add_text(end_of_header);
        add_text("x");
        send_frame();
        frame_bytes.push_back(8'h00);
        send_frame();
        drain();

        run_phase(MODE_REQUEST, 32'hFFFF_FFF8, 110, 1'b0, 1'b0);
        run_phase(MODE_RESPONSE, '0, 110, 1'b1, 1'b0);
        run_phase(MODE_REQUEST, 32'hFFFF_FFFF, 110, 1'b0, 1'b1);
        run_phase(MODE_UNKNOWN, $urandom, 90, 1'b0, 1'b0);
        run_phase(MODE_RESPONSE, 32'hFFFF_FFF0, 110, 1'b0, 1'b0);
        run_phase(MODE_RESERVED, $urandom, 60, 1'b0, 1'b0);
        run_phase(MODE_REQUEST, $urandom, 110, 1'b0, 1'b0);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/hfsf_pkg.sv
src/hfsf_cell.sv
src/http_frame_start_finder.sv
tb/sv/http_frame_start_finder_tb.sv
